[src/ecd_pkg.sv]
package ecd_pkg;

  localparam int FLOORS  = 5;
  localparam int FLOOR_W = 3;
  localparam int CNT_W   = 8;

  typedef logic [FLOOR_W-1:0]  floor_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic signed [1:0]   dir_t;

  localparam floor_t TOP_FLOOR = FLOOR_W'(FLOORS - 1);

  localparam dir_t DIR_IDLE = 2'sb00;
  localparam dir_t DIR_UP   = 2'sb01;
  localparam dir_t DIR_DOWN = 2'sb11;

  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic CFG_LOWEST_GAP = 1'b0;
  localparam logic CFG_GAP        = 1'b1;

  localparam cnt_t LOWEST_GAP_RESET = 8'd114;
  localparam cnt_t GAP_RESET        = 8'd124;

  typedef struct packed {
    logic   found;
    floor_t floor;
    logic   up;
  } scan_t;

  typedef struct packed {
    floor_t floor_now;
    dir_t   moving_dir;
    cnt_t   progress_out;
    logic   door_cycled;
    cnt_t   riders_total;
  } result_t;

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic in_dir(input floor_t f, input floor_t t, input logic up);
    return up ? (t > f) : (t < f);
  endfunction

endpackage

[src/elevator_call_dispatcher.sv]
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: from_floor, to_floor; tuser: kind
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: floor_now .. riders_total
// cfg       in   cfg_wen (no ready)             cfg_index, cfg_data
//
// one word per cycle sustained while results are taken; an accepted input word passes
// through the input register, then the whole update goes into the result register
// rst is synchronous: car at floor 0, idle, all counts zero, gaps 114 / 124
// input stalls only while the input register holds a word and the result register
// holds one that is not taken in the same cycle
module elevator_call_dispatcher import ecd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] from_floor, [5:3] to_floor, [7:6] zero
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] floor_now, [4:3] moving_dir, [12:5] progress_out,
                                      // [13] door_cycled, [21:14] riders_total, [23:22] zero
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  cnt_t    lowest_gap_ticks;
  cnt_t    gap_ticks;
  logic    in_valid;
  logic    in_kind;
  floor_t  in_from;
  floor_t  in_to;
  logic    advance;
  result_t result;
  result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_gap_ticks <= LOWEST_GAP_RESET;
      gap_ticks        <= GAP_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_LOWEST_GAP: lowest_gap_ticks <= cfg_data;
        CFG_GAP:        gap_ticks        <= cfg_data;
        default:        ;
      endcase
    end
  end

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= s_axis_tuser;
      in_from <= s_axis_tdata[2:0];
      in_to   <= s_axis_tdata[5:3];
    end
  end

  ecd_core u_core (
    .clk              (clk),
    .rst              (rst),
    .proc             (advance),
    .kind             (in_kind),
    .from_floor       (in_from),
    .to_floor         (in_to),
    .lowest_gap_ticks (lowest_gap_ticks),
    .gap_ticks        (gap_ticks),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= result;
  end

  assign m_axis_tdata = {2'b00, out_res.riders_total, out_res.door_cycled,
                         out_res.progress_out, out_res.moving_dir, out_res.floor_now};

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("processed word lost before the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !advance)
    else $error("pending result overwritten");

endmodule

[src/ecd_scan.sv]
module ecd_scan import ecd_pkg::*; (
  input  logic [FLOORS-1:0] up_wait,
  input  logic [FLOORS-1:0] dn_wait,
  output scan_t             scan
);

  // walk from the top so the earliest queue in priority order wins
  always_comb begin
    scan = '{found: 1'b0, floor: '0, up: 1'b1};
    for (int f = FLOORS - 1; f >= 0; f--) begin
      if (dn_wait[f]) begin
        scan = '{found: 1'b1, floor: FLOOR_W'(f), up: 1'b0};
      end
      if (up_wait[f]) begin
        scan = '{found: 1'b1, floor: FLOOR_W'(f), up: 1'b1};
      end
    end
  end

endmodule

[src/ecd_core.sv]
module ecd_core import ecd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    proc,
  input  logic    kind,
  input  floor_t  from_floor,
  input  floor_t  to_floor,
  input  cnt_t    lowest_gap_ticks,
  input  cnt_t    gap_ticks,
  output result_t result
);

  floor_t cur_floor;
  dir_t   travel_dir;
  cnt_t   progress;
  cnt_t   riders [FLOORS];
  cnt_t   waiting [FLOORS][FLOORS];

  floor_t cur_floor_next;
  dir_t   dir_pre;
  dir_t   travel_dir_next;
  cnt_t   progress_next;
  cnt_t   riders_next [FLOORS];
  cnt_t   waiting_next [FLOORS][FLOORS];

  logic [FLOORS-1:0] up_wait;
  logic [FLOORS-1:0] dn_wait;
  scan_t             scan;

  logic           moving_up;
  cnt_t           seg_gap;
  logic [CNT_W:0] step;
  floor_t         arrive_floor;
  logic           arrived;
  logic           door;
  logic           board_en;
  floor_t         board_floor;
  logic           board_up;
  logic           clear_en;
  logic           call_en;
  logic           car_empty;
  cnt_t           total;

  always_comb begin
    for (int f = 0; f < FLOORS; f++) begin
      up_wait[f] = 1'b0;
      dn_wait[f] = 1'b0;
      for (int t = 0; t < FLOORS; t++) begin
        if (t > f && waiting[f][t] != '0) up_wait[f] = 1'b1;
        if (t < f && waiting[f][t] != '0) dn_wait[f] = 1'b1;
      end
    end
  end

  ecd_scan u_scan (
    .up_wait (up_wait),
    .dn_wait (dn_wait),
    .scan    (scan)
  );

  assign moving_up    = (travel_dir == DIR_UP);
  assign seg_gap      = ((moving_up && cur_floor == '0) || (!moving_up && cur_floor == 1))
                        ? lowest_gap_ticks : gap_ticks;
  assign step         = {1'b0, progress} + 9'd1;
  assign arrive_floor = moving_up ? cur_floor + 1'b1 : cur_floor - 1'b1;

  // control decisions for one word
  always_comb begin
    cur_floor_next = cur_floor;
    dir_pre        = travel_dir;
    progress_next  = progress;
    door           = 1'b0;
    arrived        = 1'b0;
    board_en       = 1'b0;
    board_floor    = cur_floor;
    board_up       = 1'b1;
    clear_en       = 1'b0;
    call_en        = 1'b0;
    if (proc) begin
      if (kind == KIND_CALL) begin
        call_en = (from_floor < FLOORS) && (to_floor < FLOORS) && (from_floor != to_floor);
      end else if (travel_dir == DIR_IDLE) begin
        if (scan.found) begin
          progress_next = '0;
          if (scan.floor > cur_floor) begin
            dir_pre = DIR_UP;
          end else if (scan.floor < cur_floor) begin
            dir_pre = DIR_DOWN;
          end else begin
            board_en    = 1'b1;
            board_floor = scan.floor;
            board_up    = scan.up;
            dir_pre     = scan.up ? DIR_UP : DIR_DOWN;
            door        = 1'b1;
          end
        end
      end else if (step < {1'b0, seg_gap}) begin
        progress_next = step[CNT_W-1:0];
      end else begin
        cur_floor_next = arrive_floor;
        progress_next  = '0;
        arrived        = 1'b1;
        board_en       = 1'b1;
        board_floor    = arrive_floor;
        board_up       = moving_up;
        clear_en       = 1'b1;
        door           = (moving_up ? up_wait[arrive_floor] : dn_wait[arrive_floor])
                         || (riders[arrive_floor] != '0);
      end
    end
  end

  // count updates, all destinations in parallel
  always_comb begin
    for (int t = 0; t < FLOORS; t++) begin
      riders_next[t] = riders[t];
      if (board_en && in_dir(board_floor, FLOOR_W'(t), board_up)) begin
        riders_next[t] = sat_add(riders[t], waiting[board_floor][t]);
      end
      if (clear_en && board_floor == FLOOR_W'(t)) riders_next[t] = '0;
    end
    for (int f = 0; f < FLOORS; f++) begin
      for (int t = 0; t < FLOORS; t++) begin
        waiting_next[f][t] = waiting[f][t];
        if (board_en && board_floor == FLOOR_W'(f)
            && in_dir(board_floor, FLOOR_W'(t), board_up)) begin
          waiting_next[f][t] = '0;
        end
        if (call_en && from_floor == FLOOR_W'(f) && to_floor == FLOOR_W'(t)) begin
          waiting_next[f][t] = sat_add(waiting[f][t], 8'd1);
        end
      end
    end
  end

  always_comb begin
    car_empty = 1'b1;
    total     = '0;
    for (int t = 0; t < FLOORS; t++) begin
      if (riders_next[t] != '0) car_empty = 1'b0;
      total = sat_add(total, riders_next[t]);
    end
  end

  always_comb begin
    travel_dir_next = dir_pre;
    if (arrived && (car_empty || (moving_up && arrive_floor == TOP_FLOOR)
                    || (!moving_up && arrive_floor == '0))) begin
      travel_dir_next = DIR_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_floor  <= '0;
      travel_dir <= DIR_IDLE;
      progress   <= '0;
      for (int t = 0; t < FLOORS; t++) riders[t] <= '0;
      for (int f = 0; f < FLOORS; f++) begin
        for (int t = 0; t < FLOORS; t++) waiting[f][t] <= '0;
      end
    end else if (proc) begin
      cur_floor  <= cur_floor_next;
      travel_dir <= travel_dir_next;
      progress   <= progress_next;
      for (int t = 0; t < FLOORS; t++) riders[t] <= riders_next[t];
      for (int f = 0; f < FLOORS; f++) begin
        for (int t = 0; t < FLOORS; t++) waiting[f][t] <= waiting_next[f][t];
      end
    end
  end

  assign result = '{floor_now:    cur_floor_next,
                    moving_dir:   travel_dir_next,
                    progress_out: progress_next,
                    door_cycled:  door,
                    riders_total: total};

  a_idle_no_progress: assert property (@(posedge clk) disable iff (rst)
    travel_dir == DIR_IDLE |-> progress == '0)
    else $error("idle car with travel progress");

  a_call_keeps_car: assert property (@(posedge clk) disable iff (rst)
    proc && kind == KIND_CALL |=> $stable(cur_floor) && $stable(travel_dir) && $stable(progress))
    else $error("call word moved the car");

  a_floor_range: assert property (@(posedge clk) disable iff (rst)
    cur_floor <= TOP_FLOOR)
    else $error("car beyond top floor");

  a_hold_when_quiet: assert property (@(posedge clk) disable iff (rst)
    !proc |=> $stable(cur_floor) && $stable(travel_dir) && $stable(progress))
    else $error("car state changed without a word");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench import ecd_pkg::*;;

  localparam int LIMIT_CYCLES = 500_000;
  localparam int SETTLE       = 8;
  localparam int LONG_HOLD    = 120;
  localparam int IDLE_CAP     = 4000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [2:0] from_floor, [5:3] to_floor, [7:6] zero
  logic        s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [2:0] floor_now, [4:3] moving_dir, [12:5] progress_out,
                               // [13] door_cycled, [21:14] riders_total, [23:22] zero
  logic        cfg_wen;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  elevator_call_dispatcher uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // car model kept alongside the block
  cnt_t   lowest_span;
  cnt_t   upper_span;
  floor_t car_floor;
  dir_t   car_dir;
  cnt_t   car_progress;
  cnt_t   aboard [FLOORS];
  cnt_t   queued [FLOORS][FLOORS];

  result_t car_reports [$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_requests = 0;
  int      hold_served = 0;
  int      hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic cnt_t add_capped(input cnt_t a, input cnt_t b);
    logic [8:0] wide;
    wide = a + b;
    if (wide > 9'd255)
      return 8'd255;
    return wide[7:0];
  endfunction

  function automatic logic heads_that_way(input int f, input int t, input logic up);
    if (up)
      return t > f;
    return t < f;
  endfunction

  function automatic logic queue_has(input int f, input logic up);
    for (int t = 0; t < FLOORS; t++)
      if (heads_that_way(f, t, up) && queued[f][t] != 0)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic void board(input int f, input logic up);
    for (int t = 0; t < FLOORS; t++)
      if (heads_that_way(f, t, up)) begin
        aboard[t] = add_capped(aboard[t], queued[f][t]);
        queued[f][t] = '0;
      end
  endfunction

  function automatic logic calls_pending();
    for (int f = 0; f < FLOORS; f++)
      for (int t = 0; t < FLOORS; t++)
        if (queued[f][t] != 0)
          return 1'b1;
    return 1'b0;
  endfunction

  // idle car: first waiting queue in priority order decides where to go
  function automatic logic dispatch_idle();
    for (int f = 0; f < FLOORS; f++)
      for (int d = 0; d < 2; d++) begin
        logic up;
        up = (d == 0);
        if (queue_has(f, up)) begin
          car_progress = '0;
          if (f > car_floor) begin
            car_dir = DIR_UP;
            return 1'b0;
          end
          if (f < car_floor) begin
            car_dir = DIR_DOWN;
            return 1'b0;
          end
          board(f, up);
          car_dir = up ? DIR_UP : DIR_DOWN;
          return 1'b1;
        end
      end
    return 1'b0;
  endfunction

  function automatic logic advance_car();
    logic       up;
    logic       door;
    int         span;
    int         stepped;
    logic       empty;
    up = (car_dir == DIR_UP);
    span = ((up && car_floor == 0) || (!up && car_floor == 1)) ? lowest_span : upper_span;
    stepped = car_progress + 1;
    if (stepped < span) begin
      car_progress = cnt_t'(stepped);
      return 1'b0;
    end
    car_floor = up ? car_floor + 1'b1 : car_floor - 1'b1;
    door = queue_has(car_floor, up) || aboard[car_floor] != 0;
    board(car_floor, up);
    aboard[car_floor] = '0;
    car_progress = '0;
    empty = 1'b1;
    for (int t = 0; t < FLOORS; t++)
      if (aboard[t] != 0)
        empty = 1'b0;
    if (empty || (up && car_floor == TOP_FLOOR) || (!up && car_floor == 0))
      car_dir = DIR_IDLE;
    return door;
  endfunction

  function automatic result_t next_car_report(input logic kind, input floor_t src,
                                              input floor_t dst);
    result_t r;
    cnt_t    total;
    logic    door;
    door = 1'b0;
    if (kind == KIND_CALL) begin
      if (src < FLOORS && dst < FLOORS && src != dst)
        queued[src][dst] = add_capped(queued[src][dst], 8'd1);
    end else if (car_dir == DIR_IDLE) begin
      door = dispatch_idle();
    end else begin
      door = advance_car();
    end
    total = '0;
    for (int t = 0; t < FLOORS; t++)
      total = add_capped(total, aboard[t]);
    r.floor_now    = car_floor;
    r.moving_dir   = car_dir;
    r.progress_out = car_progress;
    r.door_cycled  = door;
    r.riders_total = total;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (car_reports.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
      end else begin
        want = car_reports.pop_front();
        check_field("floor_now", want.floor_now, m_axis_tdata[2:0]);
        check_field("moving_dir", int'(want.moving_dir), int'(dir_t'(m_axis_tdata[4:3])));
        check_field("progress_out", want.progress_out, m_axis_tdata[12:5]);
        check_field("door_cycled", want.door_cycled, m_axis_tdata[13]);
        check_field("riders_total", want.riders_total, m_axis_tdata[21:14]);
      end
    end
  end

  task automatic send_word(input logic kind, input floor_t src, input floor_t dst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, dst, src};
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    car_reports.push_back(next_car_report(kind, src, dst));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (car_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_gaps(input cnt_t lowest, input cnt_t upper);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_LOWEST_GAP;
    cfg_data  <= lowest;
    @(posedge clk);
    cfg_index <= CFG_GAP;
    cfg_data  <= upper;
    @(posedge clk);
    cfg_wen     <= 1'b0;
    lowest_span = lowest;
    upper_span  = upper;
  endtask

  task automatic run_until_idle();
    int n;
    n = 0;
    while ((car_dir != DIR_IDLE || calls_pending()) && n < IDLE_CAP) begin
      send_word(KIND_TICK, floor_t'($urandom_range(7)), floor_t'($urandom_range(7)));
      n++;
    end
  endtask

  task automatic random_items(input int count);
    int     pick;
    floor_t src;
    floor_t dst;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        src = floor_t'($urandom_range(FLOORS - 1));
        dst = floor_t'($urandom_range(FLOORS - 2));
        if (dst >= src)
          dst = dst + 1'b1;
        send_word(KIND_CALL, src, dst);
      end else if (pick < 26) begin
        send_word(KIND_CALL, floor_t'($urandom_range(7)), floor_t'($urandom_range(7)));
      end else begin
        send_word(KIND_TICK, floor_t'($urandom_range(7)), floor_t'($urandom_range(7)));
      end
    end
  endtask

  // one ride with the gap registers as they come out of reset
  task automatic test_reset_gaps();
    send_word(KIND_CALL, 3'd1, 3'd2);
    run_until_idle();
  endtask

  task automatic test_directed();
    set_gaps(8'd0, 8'd2);
    send_word(KIND_TICK, 3'd0, 3'd0);   // idle, nothing waiting
    send_word(KIND_CALL, 3'd0, 3'd0);   // same floor both ends
    send_word(KIND_CALL, 3'd7, 3'd7);
    send_word(KIND_CALL, 3'd5, 3'd2);   // floors past the top
    send_word(KIND_CALL, 3'd2, 3'd6);
    send_word(KIND_CALL, 3'd4, 3'd0);
    send_word(KIND_CALL, 3'd0, 3'd4);   // car is elsewhere, so this call waits in its queue
    send_word(KIND_CALL, 3'd3, 3'd1);
    send_word(KIND_CALL, 3'd2, 3'd3);
    run_until_idle();
  endtask

  // queue and load counts pinned at full scale
  task automatic test_saturation();
    set_gaps(8'd2, 8'd3);
    repeat (258) send_word(KIND_CALL, 3'd1, 3'd3);
    repeat (3) send_word(KIND_CALL, 3'd2, 3'd3);
    repeat (10) send_word(KIND_CALL, 3'd2, 3'd4);
    run_until_idle();
  endtask

  task automatic test_random_phases();
    int   sender_pct [3] = '{30, 66, 0};
    int   receiver_pct [3] = '{66, 30, 0};
    cnt_t lowest [3] = '{8'd1, 8'd5, 8'd2};
    cnt_t upper [3] = '{8'd3, 8'd0, 8'd1};
    for (int p = 0; p < 3; p++) begin
      set_gaps(lowest[p], upper[p]);
      send_idle_pct = sender_pct[p];
      recv_idle_pct = receiver_pct[p];
      random_items(280);
    end
  endtask

  // output held off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    random_items(40);
    wait_drained();
  endtask

  task automatic test_long_gaps();
    set_gaps(8'd255, 8'd255);
    send_idle_pct = 10;
    recv_idle_pct = 10;
    random_items(200);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_CALL;
    cfg_wen       = 1'b0;
    cfg_index     = CFG_LOWEST_GAP;
    cfg_data      = '0;
    lowest_span   = LOWEST_GAP_RESET;
    upper_span    = GAP_RESET;
    car_floor     = '0;
    car_dir       = DIR_IDLE;
    car_progress  = '0;
    for (int f = 0; f < FLOORS; f++) begin
      aboard[f] = '0;
      for (int t = 0; t < FLOORS; t++)
        queued[f][t] = '0;
    end
    send_idle_pct = 10;
    recv_idle_pct = 20;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_gaps();
    test_directed();
    test_saturation();
    test_random_phases();
    test_backpressure();
    test_long_gaps();

    wait_drained();
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

[elevator_call_dispatcher.f]
src/ecd_pkg.sv
src/ecd_scan.sv
src/ecd_core.sv
src/elevator_call_dispatcher.sv
tb/testbench.sv
